// File: src/ghkp_pkg.sv
// Shared types and constants of the GHASH key power block.
package ghkp_pkg;

   localparam int unsigned GF_WIDTH       = 128;
   localparam int unsigned HALF_WIDTH     = 64;
   localparam int unsigned INDEX_WIDTH    = 3;
   localparam int unsigned STEPS_PER_CELL = 8;
   localparam int unsigned CELLS_PER_MUL  = GF_WIDTH / STEPS_PER_CELL;
   localparam logic [7:0]  GF_REDUCE      = 8'he1;

   typedef logic [GF_WIDTH-1:0]    gf_elem_type;
   typedef logic [HALF_WIDTH-1:0]  half_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

endpackage

// File: src/ghkp_if.sv
// Handshake channels for keys in and key powers out.
interface ghkp_req_if;
   logic                 valid;
   logic                 ready;
   ghkp_pkg::half_type   key_high;
   ghkp_pkg::half_type   key_low;

   modport source (output valid, output key_high, output key_low, input ready);
   modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

interface ghkp_rsp_if;
   logic                 valid;
   logic                 ready;
   ghkp_pkg::index_type  power_index;
   ghkp_pkg::half_type   power_high;
   ghkp_pkg::half_type   power_low;
   logic                 last;

   modport source (output valid, output power_index, output power_high,
                   output power_low, output last, input ready);
   modport sink   (input valid, input power_index, input power_high,
                   input power_low, input last, output ready);
endinterface

// File: src/ghkp_cell.sv
// One cell of the multiply chain: eight shift-and-add steps of a GF(2^128) product.
module ghkp_cell #(
   parameter int NUM_POWERS = 4,
   parameter int SEG        = 1,
   parameter int STEP       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_prev,
   input  ghkp_pkg::gf_elem_type z_prev,
   input  ghkp_pkg::gf_elem_type v_prev,
   input  ghkp_pkg::gf_elem_type pow_prev [NUM_POWERS],
   output logic                  valid_out,
   output ghkp_pkg::gf_elem_type z_out,
   output ghkp_pkg::gf_elem_type v_out,
   output ghkp_pkg::gf_elem_type pow_out  [NUM_POWERS]
);

   localparam int  BASE  = int'(ghkp_pkg::GF_WIDTH) - 1
                           - STEP * int'(ghkp_pkg::STEPS_PER_CELL);
   localparam bit  FIRST = (STEP == 0);
   localparam bit  FINAL = (STEP == int'(ghkp_pkg::CELLS_PER_MUL) - 1);

   logic                  valid_ff;
   ghkp_pkg::gf_elem_type z_ff, z_in;
   ghkp_pkg::gf_elem_type v_ff, v_in;
   ghkp_pkg::gf_elem_type pow_ff [NUM_POWERS];
   ghkp_pkg::gf_elem_type pow_in [NUM_POWERS];
   ghkp_pkg::gf_elem_type x_word;
   logic                  carry;

   always_comb begin
      z_in   = FIRST ? '0 : z_prev;
      v_in   = FIRST ? pow_prev[0] : v_prev;
      x_word = pow_prev[SEG-1];
      carry  = 1'b0;
      for (int i = 0; i < int'(ghkp_pkg::STEPS_PER_CELL); i++) begin
         if (x_word[BASE-i]) begin
            z_in = z_in ^ v_in;
         end
         carry = v_in[0];
         v_in  = v_in >> 1;
         if (carry) begin
            v_in[ghkp_pkg::GF_WIDTH-1 -: 8] = v_in[ghkp_pkg::GF_WIDTH-1 -: 8]
                                              ^ ghkp_pkg::GF_REDUCE;
         end
      end
      for (int k = 0; k < NUM_POWERS; k++) begin
         pow_in[k] = pow_prev[k];
      end
      if (FINAL) begin
         pow_in[SEG] = z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff   <= z_in;
         v_ff   <= v_in;
         pow_ff <= pow_in;
      end
   end

   assign valid_out = valid_ff;
   assign z_out     = z_ff;
   assign v_out     = v_ff;
   assign pow_out   = pow_ff;

endmodule

// File: src/ghkp_emit.sv
// Output stage: holds one key's powers and sends them one transfer at a time.
module ghkp_emit #(
   parameter int NUM_POWERS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ghkp_pkg::gf_elem_type pow_prev [NUM_POWERS],
   ghkp_rsp_if.source            rsp_chan
);

   localparam int CNT_W = (NUM_POWERS > 1) ? $clog2(NUM_POWERS) : 1;

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   ghkp_pkg::index_type   index_ff, index_in;
   ghkp_pkg::gf_elem_type pow_ff [NUM_POWERS];
   ghkp_pkg::gf_elem_type pow_in [NUM_POWERS];
   logic                  final_one;
   logic                  sent;
   logic                  load;

   assign final_one = (count_ff == CNT_W'(NUM_POWERS - 1));
   assign sent      = busy_ff && rsp_chan.ready;
   assign in_ready  = !busy_ff || (rsp_chan.ready && final_one);
   assign load      = in_valid && in_ready;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      index_in = index_ff;
      pow_in   = pow_ff;
      if (load) begin
         busy_in  = 1'b1;
         count_in = '0;
         index_in = ghkp_pkg::index_type'(1);
         pow_in   = pow_prev;
      end else if (sent) begin
         if (final_one) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
            index_in = index_ff + 1'b1;
            for (int k = 0; k < NUM_POWERS - 1; k++) begin
               pow_in[k] = pow_ff[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      pow_ff <= pow_in;
   end

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.power_index = index_ff;
   assign rsp_chan.power_high  = pow_ff[0][ghkp_pkg::GF_WIDTH-1 -: ghkp_pkg::HALF_WIDTH];
   assign rsp_chan.power_low   = pow_ff[0][ghkp_pkg::HALF_WIDTH-1:0];
   assign rsp_chan.last        = final_one;

endmodule

// File: src/ghash_key_power_precompute_top.sv
// Top level: GHASH key powers H^1 to H^NUM_POWERS through a chain of multiply cells.
// The output stage sends one power a cycle while rsp_chan.ready is high, and the cells wait on it.
// Each multiply runs along 16 cells of eight bit steps; all cells advance together.
// Reset clears the valid bits of the cells and the output stage; keys in flight are dropped.
module ghash_key_power_precompute_top #(
   parameter int NUM_POWERS = 4
) (
   input  logic       clock,
   input  logic       reset,
   ghkp_req_if.sink   req_chan,
   ghkp_rsp_if.source rsp_chan
);

   localparam int NUM_CELLS = (NUM_POWERS - 1) * int'(ghkp_pkg::CELLS_PER_MUL);

   logic                  valid_s [NUM_CELLS+1];
   ghkp_pkg::gf_elem_type z_s     [NUM_CELLS+1];
   ghkp_pkg::gf_elem_type v_s     [NUM_CELLS+1];
   ghkp_pkg::gf_elem_type pow_s   [NUM_CELLS+1][NUM_POWERS];
   logic                  emit_ready;
   logic                  advance;

   assign advance        = emit_ready || !valid_s[NUM_CELLS];
   assign req_chan.ready = advance;

   assign valid_s[0] = req_chan.valid;
   assign z_s[0]     = '0;
   assign v_s[0]     = '0;

   assign pow_s[0][0] = {req_chan.key_high, req_chan.key_low};

   for (genvar k = 1; k < NUM_POWERS; k++) begin : g_pow_zero
      assign pow_s[0][k] = '0;
   end

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      localparam int SEG  = c / int'(ghkp_pkg::CELLS_PER_MUL) + 1;
      localparam int STEP = c % int'(ghkp_pkg::CELLS_PER_MUL);

      ghkp_cell #(
         .NUM_POWERS (NUM_POWERS),
         .SEG        (SEG),
         .STEP       (STEP)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_prev (valid_s[c]),
         .z_prev     (z_s[c]),
         .v_prev     (v_s[c]),
         .pow_prev   (pow_s[c]),
         .valid_out  (valid_s[c+1]),
         .z_out      (z_s[c+1]),
         .v_out      (v_s[c+1]),
         .pow_out    (pow_s[c+1])
      );
   end

   ghkp_emit #(
      .NUM_POWERS (NUM_POWERS)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_s[NUM_CELLS]),
      .in_ready (emit_ready),
      .pow_prev (pow_s[NUM_CELLS]),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/tb_ghash_key_power_precompute_top.sv
// Testbench for the GHASH key power block: key stream against a bit-serial GF(2^128) predictor.
`timescale 1ns / 100ps

module tb_ghash_key_power_precompute_top;

   localparam int NUM_POWERS   = 4;
   localparam int KEY_ROWS     = 14;
   localparam int RANDOM_KEYS  = 320;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 32;

   typedef struct packed {
      ghkp_pkg::index_type power_index;
      ghkp_pkg::half_type  power_high;
      ghkp_pkg::half_type  power_low;
      logic                last;
   } power_rec_type;

   typedef struct packed {
      ghkp_pkg::half_type                              key_high;
      ghkp_pkg::half_type                              key_low;
      logic                                            known;
      logic [NUM_POWERS-1:0][ghkp_pkg::HALF_WIDTH-1:0] pow_high;
      logic [NUM_POWERS-1:0][ghkp_pkg::HALF_WIDTH-1:0] pow_low;
   } key_row_type;

   logic clock = 1'b0;
   logic reset;

   ghkp_req_if req_chan();
   ghkp_rsp_if rsp_chan();

   ghash_key_power_precompute_top #(
      .NUM_POWERS (NUM_POWERS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   power_rec_type expected_powers[$];
   key_row_type   key_table [KEY_ROWS];
   int unsigned   mismatches   = 0;
   int unsigned   powers_seen  = 0;
   int unsigned   cycles       = 0;
   bit            hold_request = 1'b0;
   bit            hold_served  = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic ghkp_pkg::gf_elem_type gf_product(input ghkp_pkg::gf_elem_type a,
                                                        input ghkp_pkg::gf_elem_type b);
      ghkp_pkg::gf_elem_type acc;
      ghkp_pkg::gf_elem_type v;
      logic                  carry;
      acc = '0;
      v   = b;
      for (int n = 0; n < ghkp_pkg::GF_WIDTH; n++) begin
         if (a[ghkp_pkg::GF_WIDTH-1-n])
            acc ^= v;
         carry = v[0];
         v     = v >> 1;
         if (carry)
            v[ghkp_pkg::GF_WIDTH-1 -: 8] ^= ghkp_pkg::GF_REDUCE;
      end
      return acc;
   endfunction

   task automatic queue_key_powers(input ghkp_pkg::half_type h, input ghkp_pkg::half_type l);
      ghkp_pkg::gf_elem_type key;
      ghkp_pkg::gf_elem_type pw;
      power_rec_type         rec;
      key = {h, l};
      pw  = key;
      for (int k = 1; k <= NUM_POWERS; k++) begin
         if (k > 1)
            pw = gf_product(pw, key);
         rec.power_index = ghkp_pkg::index_type'(k);
         rec.power_high  = pw[ghkp_pkg::GF_WIDTH-1:ghkp_pkg::HALF_WIDTH];
         rec.power_low   = pw[ghkp_pkg::HALF_WIDTH-1:0];
         rec.last        = (k == NUM_POWERS);
         expected_powers.push_back(rec);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic offer_key(input ghkp_pkg::half_type h, input ghkp_pkg::half_type l);
      req_chan.valid    <= 1'b1;
      req_chan.key_high <= h;
      req_chan.key_low  <= l;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_sender(input bit steady);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic ghkp_pkg::gf_elem_type random_key();
      ghkp_pkg::gf_elem_type key;
      int unsigned           pick;
      pick = $urandom_range(99);
      key  = {$urandom, $urandom, $urandom, $urandom};
      if (pick < 15)
         key = ghkp_pkg::gf_elem_type'(1) << $urandom_range(ghkp_pkg::GF_WIDTH-1);
      else if (pick < 25)
         key &= {$urandom, $urandom, $urandom, $urandom} & {$urandom, $urandom, $urandom, $urandom};
      else if (pick < 35)
         key = {key[ghkp_pkg::GF_WIDTH-1 -: 8], {(ghkp_pkg::GF_WIDTH-8){1'b0}}};
      else if (pick < 40)
         key = ~(ghkp_pkg::gf_elem_type'(1) << $urandom_range(ghkp_pkg::GF_WIDTH-1));
      return key;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("ghash_key_power_precompute_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      power_rec_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         powers_seen++;
         if (expected_powers.size() == 0) begin
            report_mismatch($sformatf("unexpected power H^%0d %h_%h", rsp_chan.power_index,
                                      rsp_chan.power_high, rsp_chan.power_low));
         end else begin
            want = expected_powers.pop_front();
            if (rsp_chan.power_index !== want.power_index)
               report_mismatch($sformatf("power_index %0d, want %0d",
                                         rsp_chan.power_index, want.power_index));
            if (rsp_chan.power_high !== want.power_high)
               report_mismatch($sformatf("H^%0d power_high %h, want %h", want.power_index,
                                         rsp_chan.power_high, want.power_high));
            if (rsp_chan.power_low !== want.power_low)
               report_mismatch($sformatf("H^%0d power_low %h, want %h", want.power_index,
                                         rsp_chan.power_low, want.power_low));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("H^%0d last %b, want %b", want.power_index,
                                         rsp_chan.last, want.last));
         end
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_chan.ready <= 1'b0;
            hold_served = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= (powers_seen >= 400 && powers_seen < 700)
                           || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   initial begin
      ghkp_pkg::gf_elem_type key;
      power_rec_type         rec;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.key_high <= '0;
      req_chan.key_low  <= '0;
      key_table = '{
         '{64'h0, 64'h0, 1'b1, {4{64'h0}}, {4{64'h0}}},
         '{64'h8000000000000000, 64'h0, 1'b1, {4{64'h8000000000000000}}, {4{64'h0}}},
         '{64'h4000000000000000, 64'h0, 1'b1,
           {64'h0800000000000000, 64'h1000000000000000,
            64'h2000000000000000, 64'h4000000000000000}, {4{64'h0}}},
         '{64'h0100000000000000, 64'h0, 1'b1,
           {64'h0000000800000000, 64'h0000040000000000,
            64'h0002000000000000, 64'h0100000000000000}, {4{64'h0}}},
         '{64'h0, 64'h1, 1'b0, '0, '0},
         '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, '0, '0},
         '{64'hffffffffffffffff, 64'h0, 1'b0, '0, '0},
         '{64'h0, 64'hffffffffffffffff, 1'b0, '0, '0},
         '{64'h5555555555555555, 64'h5555555555555555, 1'b0, '0, '0},
         '{64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0},
         '{64'h1, 64'h0, 1'b0, '0, '0},
         '{64'h0, 64'h8000000000000000, 1'b0, '0, '0},
         '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, '0, '0},
         '{64'h0, 64'h80, 1'b0, '0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (key_table[i]) begin
         idle_sender(1'b0);
         offer_key(key_table[i].key_high, key_table[i].key_low);
         if (key_table[i].known) begin
            for (int k = 1; k <= NUM_POWERS; k++) begin
               rec.power_index = ghkp_pkg::index_type'(k);
               rec.power_high  = key_table[i].pow_high[k-1];
               rec.power_low   = key_table[i].pow_low[k-1];
               rec.last        = (k == NUM_POWERS);
               expected_powers.push_back(rec);
            end
         end else begin
            queue_key_powers(key_table[i].key_high, key_table[i].key_low);
         end
      end

      for (int n = 0; n < RANDOM_KEYS; n++) begin
         if (n == 120)
            hold_request = 1'b1;
         if (n == 220) begin
            // drain everything before carrying on
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (expected_powers.size() != 0);
         end
         idle_sender(n >= 40 && n < 100);
         key = random_key();
         offer_key(key[ghkp_pkg::GF_WIDTH-1:ghkp_pkg::HALF_WIDTH],
                   key[ghkp_pkg::HALF_WIDTH-1:0]);
         queue_key_powers(key[ghkp_pkg::GF_WIDTH-1:ghkp_pkg::HALF_WIDTH],
                          key[ghkp_pkg::HALF_WIDTH-1:0]);
      end
      req_chan.valid <= 1'b0;

      while (expected_powers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_powers.size() == 0)
         $display("ghash_key_power_precompute_top: match");
      else
         $display("ghash_key_power_precompute_top: mismatch");
      $finish;
   end

endmodule
